[hw/rtl/slew_limited_pose_smoother_top_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the pose smoother
// Implication and next-cycle checks, compiled out with NO_ASSERTIONS.
// -----------------------------------------------------------------------------
`ifndef SLEW_LIMITED_POSE_SMOOTHER_TOP_MACROS_SVH
`define SLEW_LIMITED_POSE_SMOOTHER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SLSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SLSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define SLSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/slsm_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slsm_pkg
// Widths, register indexes and shared types of the pose smoother.
// -----------------------------------------------------------------------------
package slsm_pkg;

  localparam int ANGLE_W   = 18;
  localparam int COEFF_W   = 16;
  localparam int STEP_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int EST_FRAC  = 6;
  localparam int EST_W     = ANGLE_W + EST_FRAC;
  localparam int DIFF_W    = EST_W + 1;
  localparam int ACC_W     = EST_W + 2;
  localparam int CNT_W     = $clog2(COEFF_W);
  localparam int SLEW_W    = ((ANGLE_W + 1) > (STEP_W + 1)) ? (ANGLE_W + 2) : (STEP_W + 2);

  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_COEFF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_COEFF = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_LIMIT_RST = 16'd51;
  localparam logic [COEFF_W-1:0] COEFF_RST      = COEFF_W'(6554);

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [EST_W-1:0]   est_t;
  typedef logic [COEFF_W-1:0]        coeff_t;

  typedef struct packed {
    logic   start;
    est_t   est;
    est_t   x;
    coeff_t coeff;
  } blend_req_t;

endpackage

[hw/rtl/slew_limited_pose_smoother_top.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slew_limited_pose_smoother_top
// Slew limiter for pose and antenna commands with two-stage pose smoothing.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one control tick per transaction with
//   the mode and six target angles. Output channel (out_valid / out_stall):
//   one result per tick with six commands, four feedback values and pose_sent.
//   cfg_we / cfg_index / cfg_data write the step limit, lag_coeff and
//   smooth_coeff; write only while no tick is in flight. Indexes beyond the
//   list are ignored.
// Sequence:
//   The slew step is done in the accept cycle. Eight blends then run on one
//   bit-serial multiplier (one coefficient bit per cycle), and the result is
//   then registered in ST_OUT. The next tick is accepted only once the block
//   is back in idle after that, so one tick is processed at a time.
// Reset:
//   rst_n clears all commands, estimates and the output valid, and loads the
//   register defaults (step limit 51, both coefficients 6554).
// Stall:
//   A result waits in the output register while out_stall is high; the block
//   can accept and process the next tick meanwhile and holds that one until
//   the output register frees up.
// -----------------------------------------------------------------------------
module slew_limited_pose_smoother_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [slsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slsm_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  slsm_pkg::angle_t                 in_target_roll,
  input  slsm_pkg::angle_t                 in_target_pitch,
  input  slsm_pkg::angle_t                 in_target_yaw,
  input  slsm_pkg::angle_t                 in_target_body,
  input  slsm_pkg::angle_t                 in_target_ant_right,
  input  slsm_pkg::angle_t                 in_target_ant_left,
  output logic                             out_valid,
  input  logic                             out_stall,
  output slsm_pkg::angle_t                 out_cmd_roll,
  output slsm_pkg::angle_t                 out_cmd_pitch,
  output slsm_pkg::angle_t                 out_cmd_yaw,
  output slsm_pkg::angle_t                 out_cmd_body,
  output slsm_pkg::angle_t                 out_cmd_ant_right,
  output slsm_pkg::angle_t                 out_cmd_ant_left,
  output slsm_pkg::angle_t                 out_fb_roll,
  output slsm_pkg::angle_t                 out_fb_pitch,
  output slsm_pkg::angle_t                 out_fb_yaw,
  output slsm_pkg::angle_t                 out_fb_body,
  output logic                             out_pose_sent
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GO   = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [2:0] idx_r;        // {axis, stage}

  logic [slsm_pkg::STEP_W-1:0] step_limit_r;
  slsm_pkg::coeff_t            lag_coeff_r, smooth_coeff_r;

  slsm_pkg::angle_t pose_r   [4];
  slsm_pkg::angle_t ant_r    [2];
  slsm_pkg::est_t   lag_r    [4];
  slsm_pkg::est_t   smooth_r [4];
  logic             pose_sent_r;

  slsm_pkg::angle_t pose_nxt [4];
  slsm_pkg::angle_t ant_nxt  [2];
  slsm_pkg::angle_t tgt      [4];

  slsm_pkg::blend_req_t req;
  logic                 blend_done;
  slsm_pkg::est_t       blend_res;
  logic [1:0]           axis;
  logic signed [slsm_pkg::EST_W:0] fb_sum [4];

  logic             out_valid_r;
  slsm_pkg::angle_t out_cmd_r [6];
  slsm_pkg::angle_t out_fb_r  [4];
  logic             out_sent_r;

  assign tgt[0] = in_target_roll;
  assign tgt[1] = in_target_pitch;
  assign tgt[2] = in_target_yaw;
  assign tgt[3] = in_target_body;

  for (genvar g = 0; g < 4; g++) begin : g_pose
    slsm_slew u_slew (
      .cur(pose_r[g]), .target(tgt[g]), .step(step_limit_r), .next(pose_nxt[g])
    );
  end

  slsm_slew u_slew_ar (
    .cur(ant_r[0]), .target(in_target_ant_right), .step(step_limit_r), .next(ant_nxt[0])
  );
  slsm_slew u_slew_al (
    .cur(ant_r[1]), .target(in_target_ant_left), .step(step_limit_r), .next(ant_nxt[1])
  );

  // stage 0: lag toward command; stage 1: feedback toward updated lag
  assign axis = idx_r[2:1];
  always_comb begin
    req.start = (state_r == ST_GO);
    if (idx_r[0]) begin
      req.est   = smooth_r[axis];
      req.x     = lag_r[axis];
      req.coeff = smooth_coeff_r;
    end else begin
      req.est   = lag_r[axis];
      req.x     = {pose_r[axis], {slsm_pkg::EST_FRAC{1'b0}}};
      req.coeff = lag_coeff_r;
    end
  end

  slsm_blend u_blend (
    .clk(clk), .rst_n(rst_n), .req(req), .done(blend_done), .result(blend_res)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fb_sum[i] = (slsm_pkg::EST_W + 1)'(smooth_r[i]) +
                  (slsm_pkg::EST_W + 1)'(1 << (slsm_pkg::EST_FRAC - 1));
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_limit_r   <= slsm_pkg::STEP_LIMIT_RST;
      lag_coeff_r    <= slsm_pkg::COEFF_RST;
      smooth_coeff_r <= slsm_pkg::COEFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slsm_pkg::REG_STEP_LIMIT:   step_limit_r   <= cfg_data[slsm_pkg::STEP_W-1:0];
        slsm_pkg::REG_LAG_COEFF:    lag_coeff_r    <= cfg_data[slsm_pkg::COEFF_W-1:0];
        slsm_pkg::REG_SMOOTH_COEFF: smooth_coeff_r <= cfg_data[slsm_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      pose_sent_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pose_r[i]   <= '0;
        lag_r[i]    <= '0;
        smooth_r[i] <= '0;
      end
      ant_r[0] <= '0;
      ant_r[1] <= '0;
    end else begin
      // load a new result when the register frees up; hold one that is stalled
      out_valid_r <= (state_r == ST_OUT && (!out_valid_r || !out_stall)) ||
                     (out_valid_r && out_stall);
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (!in_cmd) begin
              for (int i = 0; i < 4; i++) pose_r[i] <= pose_nxt[i];
            end
            ant_r[0]    <= ant_nxt[0];
            ant_r[1]    <= ant_nxt[1];
            pose_sent_r <= !in_cmd;
            idx_r       <= '0;
            state_r     <= ST_GO;
          end
        end
        ST_GO: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (blend_done) begin
            if (idx_r[0]) begin
              smooth_r[axis] <= blend_res;
            end else begin
              lag_r[axis] <= blend_res;
            end
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r == 3'd7) ? ST_OUT : ST_GO;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      for (int i = 0; i < 4; i++) begin
        out_cmd_r[i] <= pose_r[i];
        out_fb_r[i]  <= fb_sum[i][slsm_pkg::EST_W-1:slsm_pkg::EST_FRAC];
      end
      out_cmd_r[4] <= ant_r[0];
      out_cmd_r[5] <= ant_r[1];
      out_sent_r   <= pose_sent_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cmd_roll      = out_cmd_r[0];
  assign out_cmd_pitch     = out_cmd_r[1];
  assign out_cmd_yaw       = out_cmd_r[2];
  assign out_cmd_body      = out_cmd_r[3];
  assign out_cmd_ant_right = out_cmd_r[4];
  assign out_cmd_ant_left  = out_cmd_r[5];
  assign out_fb_roll       = out_fb_r[0];
  assign out_fb_pitch      = out_fb_r[1];
  assign out_fb_yaw        = out_fb_r[2];
  assign out_fb_body       = out_fb_r[3];
  assign out_pose_sent     = out_sent_r;

endmodule

[hw/rtl/slsm_slew.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slsm_slew
// Moves one command toward its target by at most the step limit.
// -----------------------------------------------------------------------------
module slsm_slew (
  input  slsm_pkg::angle_t           cur,
  input  slsm_pkg::angle_t           target,
  input  logic [slsm_pkg::STEP_W-1:0] step,
  output slsm_pkg::angle_t           next
);

  logic signed [slsm_pkg::SLEW_W-1:0] delta;
  logic signed [slsm_pkg::SLEW_W-1:0] lim;
  logic signed [slsm_pkg::SLEW_W-1:0] delta_cl;
  logic signed [slsm_pkg::SLEW_W-1:0] sum;

  always_comb begin
    delta = slsm_pkg::SLEW_W'(target) - slsm_pkg::SLEW_W'(cur);
    lim   = $signed(slsm_pkg::SLEW_W'(step));
    priority if (delta > lim) begin
      delta_cl = lim;
    end else if (delta < -lim) begin
      delta_cl = -lim;
    end else begin
      delta_cl = delta;
    end
    sum  = slsm_pkg::SLEW_W'(cur) + delta_cl;
    next = sum[slsm_pkg::ANGLE_W-1:0];
  end

endmodule

[hw/rtl/slsm_blend.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slsm_blend
// Bit-serial exponential blend: est + round(coeff * (x - est) / 2^COEFF_W).
// -----------------------------------------------------------------------------
`include "slew_limited_pose_smoother_top_macros.svh"

module slsm_blend (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slsm_pkg::blend_req_t req,
  output logic                 done,
  output slsm_pkg::est_t       result
);

  localparam logic [slsm_pkg::CNT_W-1:0] CNT_LAST = slsm_pkg::CNT_W'(slsm_pkg::COEFF_W - 1);

  logic signed [slsm_pkg::DIFF_W-1:0] diff_r;
  slsm_pkg::est_t                     est_r;
  slsm_pkg::coeff_t                   coeff_r, coeff_nxt;
  logic signed [slsm_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [slsm_pkg::ACC_W-1:0]  sum;
  logic                               rnd_r;
  logic [slsm_pkg::CNT_W-1:0]         cnt_r;
  logic                               busy_r, done_r;

  // one coefficient bit per cycle, LSB first; shifted-out bits drop
  always_comb begin
    sum       = acc_r + (coeff_r[0] ? slsm_pkg::ACC_W'(diff_r) : '0);
    acc_nxt   = sum >>> 1;
    coeff_nxt = coeff_r >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      diff_r  <= slsm_pkg::DIFF_W'(req.x) - slsm_pkg::DIFF_W'(req.est);
      est_r   <= req.est;
      coeff_r <= req.coeff;
      acc_r   <= '0;
      rnd_r   <= 1'b0;
    end else if (busy_r) begin
      acc_r   <= acc_nxt;
      coeff_r <= coeff_nxt;
      rnd_r   <= sum[0];
    end
  end

  // last shifted-out bit is the half-unit: round half up
  assign done   = done_r;
  assign result = est_r + acc_r[slsm_pkg::EST_W-1:0] + slsm_pkg::EST_W'(rnd_r);

  `SLSM_ASSERT_SAME(a_no_restart, clk, rst_n, req.start, !busy_r, "blend restarted while busy")
  `SLSM_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_r && cnt_r == '0, "blend did not start")
  `SLSM_ASSERT_NEXT(a_last_done, clk, rst_n, busy_r && cnt_r == CNT_LAST && !req.start, done_r && !busy_r, "blend did not finish")
  `SLSM_ASSERT_SAME(a_done_idle, clk, rst_n, done_r, !busy_r, "done while busy")

endmodule

[sim/slew_limited_pose_smoother_top_test.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// slew_limited_pose_smoother_top_test
// Self-checking bench for the pose smoother. A directed table covers range
// extremes, both modes, zero and wide slew steps and zero coefficients. Random
// phases follow with new register settings and varied idling on both channels.
// Untyped results are compared against a behavioral model of the slew limiter
// and of the two smoothing stages; typed rows give their expected values.
// -----------------------------------------------------------------------------
module slew_limited_pose_smoother_top_test;
  import slsm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 225;
  localparam int NUM_PHASES   = 8;
  localparam int NUM_DIR      = 20;

  localparam logic MODE_POSE  = 1'b0;
  localparam logic MODE_JOINT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam angle_t AMAX = angle_t'(131071);
  localparam angle_t AMIN = angle_t'(-131072);

  typedef angle_t [0:5] targets_t;

  typedef struct packed {
    logic     mode;
    targets_t tgt;
  } tick_t;

  // commands roll..body, antennas right/left, feedback roll..body
  typedef struct packed {
    angle_t [0:9] val;
    logic         pose_sent;
  } report_t;

  typedef struct packed {
    logic         set_cfg;
    logic [15:0]  step;
    logic [15:0]  lag;
    logic [15:0]  smooth;
    logic         mode;
    targets_t     tgt;
    logic         typed;
    angle_t       exp_pose;
    angle_t       exp_ant;
    logic         exp_ps;
  } row_t;

  localparam targets_t TGT_MAX  = '{6{AMAX}};
  localparam targets_t TGT_MIN  = '{6{AMIN}};
  localparam targets_t TGT_ZERO = '{6{angle_t'(0)}};
  localparam targets_t TGT_MIX  = '{12800, -6400, 2560, -2560, 1280, -1280};
  localparam targets_t TGT_FINE = '{5, -5, 300, -300, AMAX, AMIN};

  // Coefficients stay zero through the typed rows, so feedback reads zero there.
  localparam row_t DIR_ROWS [NUM_DIR] = '{
    //  cfg   step       lag       smooth    mode        targets          typed pose ant  ps
    '{1'b1, 16'd51,    16'd0,    16'd0,    MODE_POSE,  TGT_MAX,           1'b1, 51,  51,  1'b1},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_POSE,  TGT_MIN,           1'b1, 0,   0,   1'b1},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_JOINT, TGT_MAX,           1'b1, 0,   51,  1'b0},
    '{1'b1, 16'd0,     16'd0,    16'd0,    MODE_POSE,  TGT_MAX,           1'b1, 0,   51,  1'b1},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_JOINT, TGT_MIN,           1'b1, 0,   51,  1'b0},
    '{1'b1, 16'hFFFF,  16'd0,    16'd0,    MODE_POSE,  '{6{angle_t'(65535)}},
                                                                          1'b1, 65535, 65535, 1'b1},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_POSE,  TGT_MAX,           1'b1, 131070, 131070, 1'b1},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_POSE,  TGT_MIN,           1'b1, 65535, 65535, 1'b1},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_JOINT, TGT_ZERO,          1'b1, 65535, 0,   1'b0},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_POSE,  '{6{angle_t'(1000)}},
                                                                          1'b1, 1000, 1000, 1'b1},
    '{1'b1, 16'hFFFF,  16'hFFFF, 16'hFFFF, MODE_POSE,  '{AMAX, AMIN, 0, -1, 1, -1000},
                                                                          1'b0, 0,   0,   1'b0},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_JOINT, '{AMIN, AMAX, -1, 0, -1000, 1},
                                                                          1'b0, 0,   0,   1'b0},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_POSE,  TGT_MIN,           1'b0, 0,   0,   1'b0},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_POSE,  TGT_MAX,           1'b0, 0,   0,   1'b0},
    '{1'b1, 16'd1,     16'd1,    16'h8000, MODE_POSE,  TGT_FINE,          1'b0, 0,   0,   1'b0},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_JOINT, TGT_FINE,          1'b0, 0,   0,   1'b0},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_POSE,  TGT_ZERO,          1'b0, 0,   0,   1'b0},
    '{1'b1, 16'd51,    16'd6554, 16'd6554, MODE_POSE,  TGT_MIX,           1'b0, 0,   0,   1'b0},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_JOINT, TGT_MIX,           1'b0, 0,   0,   1'b0},
    '{1'b0, 16'd0,     16'd0,    16'd0,    MODE_POSE,  TGT_MIX,           1'b0, 0,   0,   1'b0}
  };

  localparam angle_t EXTREMES [4] = '{AMAX, AMIN, angle_t'(0), angle_t'(-1)};

  string FIELD_NAMES [10] = '{"cmd_roll", "cmd_pitch", "cmd_yaw", "cmd_body",
                              "cmd_ant_right", "cmd_ant_left",
                              "fb_roll", "fb_pitch", "fb_yaw", "fb_body"};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_LIMIT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = MODE_POSE;
  angle_t               in_target_roll = '0;
  angle_t               in_target_pitch = '0;
  angle_t               in_target_yaw = '0;
  angle_t               in_target_body = '0;
  angle_t               in_target_ant_right = '0;
  angle_t               in_target_ant_left = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  angle_t               out_cmd_roll;
  angle_t               out_cmd_pitch;
  angle_t               out_cmd_yaw;
  angle_t               out_cmd_body;
  angle_t               out_cmd_ant_right;
  angle_t               out_cmd_ant_left;
  angle_t               out_fb_roll;
  angle_t               out_fb_pitch;
  angle_t               out_fb_yaw;
  angle_t               out_fb_body;
  logic                 out_pose_sent;

  // model state, at reset values
  longint cmd_pos [4] = '{0, 0, 0, 0};
  longint ant_pos [2] = '{0, 0};
  longint lag_est [4] = '{0, 0, 0, 0};
  longint fb_est  [4] = '{0, 0, 0, 0};
  longint step_lim = 51;
  longint lag_w    = 6554;
  longint smooth_w = 6554;

  report_t     pending_reports [$];
  int          mismatches = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  slew_limited_pose_smoother_top u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint slew_toward(longint cur, longint tgt);
    longint d;
    d = tgt - cur;
    if (d > step_lim) d = step_lim;
    if (d < -step_lim) d = -step_lim;
    return cur + d;
  endfunction

  // est += round_half_up(w * (x - est) / 2^COEFF_W)
  function automatic longint blend_toward(longint est, longint x, longint w);
    return est + ((w * (x - est) + (longint'(1) <<< (COEFF_W - 1))) >>> COEFF_W);
  endfunction

  function automatic report_t next_pose_report(tick_t t);
    report_t r;
    if (t.mode == MODE_POSE) begin
      for (int i = 0; i < 4; i++)
        cmd_pos[i] = slew_toward(cmd_pos[i], longint'(signed'(t.tgt[i])));
    end
    for (int i = 0; i < 2; i++)
      ant_pos[i] = slew_toward(ant_pos[i], longint'(signed'(t.tgt[4 + i])));
    for (int i = 0; i < 4; i++) begin
      lag_est[i] = blend_toward(lag_est[i], cmd_pos[i] <<< EST_FRAC, lag_w);
      fb_est[i]  = blend_toward(fb_est[i], lag_est[i], smooth_w);
      r.val[i]     = angle_t'(cmd_pos[i]);
      r.val[6 + i] = angle_t'((fb_est[i] + (longint'(1) <<< (EST_FRAC - 1))) >>> EST_FRAC);
    end
    r.val[4] = angle_t'(ant_pos[0]);
    r.val[5] = angle_t'(ant_pos[1]);
    r.pose_sent = (t.mode == MODE_POSE);
    return r;
  endfunction

  // Half of the targets, on average, lie near the current command so the limiter settles and tracks.
  function automatic tick_t random_tick();
    tick_t  t;
    longint cur;
    longint span;
    t.mode = ($urandom_range(9) < 3) ? MODE_JOINT : MODE_POSE;
    span = step_lim * 2 + 4;
    for (int i = 0; i < 6; i++) begin
      cur = (i < 4) ? cmd_pos[i] : ant_pos[i - 4];
      case ($urandom_range(3))
        0: t.tgt[i] = angle_t'($urandom);
        1: t.tgt[i] = EXTREMES[$urandom_range(3)];
        default: t.tgt[i] = angle_t'(cur + longint'($urandom_range(0, 2 * span)) - span);
      endcase
    end
    return t;
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3, 4: return 16'($urandom_range(2, 400));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] step, input logic [15:0] lag,
                              input logic [15:0] smooth);
    in_valid <= 1'b0;
    wait_drained();
    put_reg(REG_STEP_LIMIT, step);
    put_reg(REG_LAG_COEFF, lag);
    put_reg(REG_SMOOTH_COEFF, smooth);
    // unused index: must leave all registers alone
    put_reg(REG_NONE, 16'($urandom));
    cfg_we <= 1'b0;
    step_lim = step;
    lag_w    = lag;
    smooth_w = smooth;
  endtask

  task automatic send_tick(input tick_t t, input logic typed, input report_t want);
    report_t predicted;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 160)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cmd              <= t.mode;
    in_target_roll      <= t.tgt[0];
    in_target_pitch     <= t.tgt[1];
    in_target_yaw       <= t.tgt[2];
    in_target_body      <= t.tgt[3];
    in_target_ant_right <= t.tgt[4];
    in_target_ant_left  <= t.tgt[5];
    do @(posedge clk); while (in_stall);
    predicted = next_pose_report(t);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  // Check the output transaction, then pick the next stall (long holds let the
  // block fill up behind a waiting result).
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.val = '{out_cmd_roll, out_cmd_pitch, out_cmd_yaw, out_cmd_body,
                  out_cmd_ant_right, out_cmd_ant_left,
                  out_fb_roll, out_fb_pitch, out_fb_yaw, out_fb_body};
      got.pose_sent = out_pose_sent;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with no expected result", $time);
      end else begin
        want = pending_reports.pop_front();
        for (int i = 0; i < 10; i++) begin
          if (got.val[i] !== want.val[i]) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, FIELD_NAMES[i],
                     signed'(want.val[i]), signed'(got.val[i]));
          end
        end
        if (got.pose_sent !== want.pose_sent) begin
          mismatches++;
          $display("%0t: pose_sent expected %0b, actual %0b", $time,
                   want.pose_sent, got.pose_sent);
        end
      end
    end
    if (hold_left != 0)
      hold_left--;
    else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
      hold_left = $urandom_range(1, 300);
    out_stall <= (hold_left != 0);
  end

  initial begin
    tick_t   t;
    report_t want;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[k]) begin
      if (DIR_ROWS[k].set_cfg)
        write_config(DIR_ROWS[k].step, DIR_ROWS[k].lag, DIR_ROWS[k].smooth);
      t.mode = DIR_ROWS[k].mode;
      t.tgt  = DIR_ROWS[k].tgt;
      want.val = '{DIR_ROWS[k].exp_pose, DIR_ROWS[k].exp_pose, DIR_ROWS[k].exp_pose,
                   DIR_ROWS[k].exp_pose, DIR_ROWS[k].exp_ant, DIR_ROWS[k].exp_ant,
                   angle_t'(0), angle_t'(0), angle_t'(0), angle_t'(0)};
      want.pose_sent = DIR_ROWS[k].exp_ps;
      send_tick(t, DIR_ROWS[k].typed, want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_config(pick_step(), pick_coeff(), pick_coeff());
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      repeat (PHASE_ITEMS) send_tick(random_tick(), 1'b0, want);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/slsm_pkg.sv
hw/rtl/slsm_slew.sv
hw/rtl/slsm_blend.sv
hw/rtl/slew_limited_pose_smoother_top.sv
sim/slew_limited_pose_smoother_top_test.sv
